/* rtl/gmsig_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmsig_pkg
// shared types, constants and helpers for the grid mesh skirt index generator
// ----------------------------------------------------------------------------
package gmsig_pkg;

    localparam int DIM_W     = 11;   // grid dimension register width
    localparam int CNT_W     = 10;   // cell column / row counter width
    localparam int IDX_W     = 21;   // vertex index width
    localparam int CFG_IDX_W = 2;    // configuration register index width
    localparam int CFG_W     = 11;   // configuration data width

    localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;
    localparam logic [DIM_W-1:0] MIN_DIM = 11'd2;
    localparam logic [DIM_W-1:0] DIM_RST = 11'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    // generation regions
    localparam logic [1:0] PH_TOP = 2'd0;
    localparam logic [1:0] PH_ROW = 2'd1;
    localparam logic [1:0] PH_COL = 2'd2;
    localparam logic [1:0] PH_BOT = 2'd3;

    localparam logic [1:0] SLOT_LAST = 2'd3;

    // grid geometry derived from the configuration registers
    typedef struct packed {
        logic [DIM_W-1:0] w;       // clamped width
        logic [CNT_W-1:0] w_m2;    // w - 2, last cell column
        logic [CNT_W-1:0] h_m2;    // h - 2, last cell row
        logic [IDX_W-1:0] n;       // w * h, bottom vertex offset
        logic [IDX_W-1:0] l;       // w * (h - 1), first vertex of last row
    } dims_t;

    // generation position
    typedef struct packed {
        logic [1:0]       phase;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        logic [1:0]       slot;
        logic [IDX_W-1:0] row_base;
    } gen_state_t;

    // one emitted triangle
    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic [1:0]       region;
        logic             last;
    } tri_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d < MIN_DIM)
            r = MIN_DIM;
        else if (d > MAX_DIM)
            r = MAX_DIM;
        else
            r = d;
        return r;
    endfunction

endpackage

/* rtl/grid_mesh_skirt_index_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_mesh_skirt_index_generator_unit
// triangle index stream for a vertex grid closed into a slab with skirts
// ----------------------------------------------------------------------------
// Each input transaction yields exactly one triangle, one per clock cycle when
// the output side keeps taking them: the position counters and corner adders
// sit between the position registers and the result register, with no loop
// over cycles. The list runs top surface (two triangles per cell), row skirts
// (four per row), column skirts (four per column), then the bottom surface
// offset by width*height; end_of_mesh marks its last triangle, after which the
// stream wraps. restart=1 rewinds to the first top triangle before emitting.
// Writing grid_width or grid_height also rewinds; values are clamped to
// 2..1024. The grid size product is formed by a multiplier at write time, so
// an item may follow a write on the very next cycle.
// ----------------------------------------------------------------------------
module grid_mesh_skirt_index_generator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [gmsig_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gmsig_pkg::CFG_W-1:0]     cfg_data,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            restart,
    // triangle channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [gmsig_pkg::IDX_W-1:0]     corner_a,
    output logic [gmsig_pkg::IDX_W-1:0]     corner_b,
    output logic [gmsig_pkg::IDX_W-1:0]     corner_c,
    output logic [1:0]                      region,
    output logic                            end_of_mesh
);
    import gmsig_pkg::*;

    dims_t      dims;
    logic       rewind;
    logic       accept;
    gen_state_t cur;
    gen_state_t state;
    tri_t       tri_c;

    logic       out_valid_reg, out_valid_next;
    tri_t       result_reg;

    // a new transaction enters whenever the result register is empty or drains
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    gmsig_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dims      (dims),
        .rewind    (rewind)
    );

    gmsig_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .restart (restart),
        .rewind  (rewind),
        .dims    (dims),
        .cur     (cur),
        .state   (state)
    );

    gmsig_tri u_tri (
        .cur   (cur),
        .dims  (dims),
        .tri_o (tri_c)
    );

    // result register valid flag
    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= tri_c;
    end

    assign out_valid   = out_valid_reg;
    assign corner_a    = result_reg.a;
    assign corner_b    = result_reg.b;
    assign corner_c    = result_reg.c;
    assign region      = result_reg.region;
    assign end_of_mesh = result_reg.last;

`ifndef SYNTHESIS
    // end of mesh only ever comes from the bottom surface
    a_last_in_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_mesh) |-> (region == PH_BOT))
        else $error("end_of_mesh outside bottom region");

    // emitting the final triangle wraps back to the first top triangle
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && tri_c.last) |=>
            (state.phase == PH_TOP && state.slot == 2'd0
             && state.col == '0 && state.row == '0 && state.row_base == '0))
        else $error("sequence did not wrap after final triangle");

    // surfaces use only two triangle slots
    a_surface_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state.phase == PH_TOP || state.phase == PH_BOT) |-> (state.slot[1] == 1'b0))
        else $error("surface triangle slot out of range");

    // an accepted transaction always shows up in the result register
    a_accept_valid: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted transaction lost");
`endif

endmodule

/* rtl/gmsig_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmsig_cfg
// grid dimension registers with clamping and precomputed vertex offsets
// ----------------------------------------------------------------------------
module gmsig_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gmsig_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gmsig_pkg::CFG_W-1:0]     cfg_data,
    output gmsig_pkg::dims_t                dims,
    output logic                            rewind
);
    import gmsig_pkg::*;

    localparam logic [IDX_W-1:0] N_RST = IDX_W'(DIM_RST) * IDX_W'(DIM_RST);
    localparam logic [IDX_W-1:0] L_RST = IDX_W'(DIM_RST) * IDX_W'(DIM_RST - 11'd1);

    logic [DIM_W-1:0] w_reg, w_next;
    logic [DIM_W-1:0] h_reg, h_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] l_reg, l_next;
    logic             wr_w, wr_h;
    logic [DIM_W-1:0] h_m1;

    assign wr_w   = cfg_we && (cfg_index == REG_GRID_WIDTH);
    assign wr_h   = cfg_we && (cfg_index == REG_GRID_HEIGHT);
    assign rewind = wr_w || wr_h;

    assign w_next = wr_w ? clamp_dim(cfg_data) : w_reg;
    assign h_next = wr_h ? clamp_dim(cfg_data) : h_reg;
    assign h_m1   = h_next - 11'd1;

    // two parallel products, both settled at write time
    assign n_next = IDX_W'(w_next) * IDX_W'(h_next);
    assign l_next = IDX_W'(w_next) * IDX_W'(h_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= DIM_RST;
            h_reg <= DIM_RST;
            n_reg <= N_RST;
            l_reg <= L_RST;
        end
        else if (rewind)
        begin
            w_reg <= w_next;
            h_reg <= h_next;
            n_reg <= n_next;
            l_reg <= l_next;
        end
    end

    assign dims.w    = w_reg;
    assign dims.w_m2 = CNT_W'(w_reg - 11'd2);
    assign dims.h_m2 = CNT_W'(h_reg - 11'd2);
    assign dims.n    = n_reg;
    assign dims.l    = l_reg;

endmodule

/* rtl/gmsig_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmsig_seq
// position sequencer: region, cell column, cell row and triangle slot
// ----------------------------------------------------------------------------
module gmsig_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   restart,
    input  logic                   rewind,
    input  gmsig_pkg::dims_t       dims,
    output gmsig_pkg::gen_state_t  cur,
    output gmsig_pkg::gen_state_t  state
);
    import gmsig_pkg::*;

    gen_state_t state_reg, state_next;
    gen_state_t eff;
    gen_state_t adv;
    logic       out_of_range;
    logic       col_last, row_last;

    assign state = state_reg;

    // position actually used for this transaction
    assign out_of_range = (state_reg.col > dims.w_m2) || (state_reg.row > dims.h_m2);
    assign eff = (restart || out_of_range) ? '0 : state_reg;
    assign cur = eff;

    assign col_last = (eff.col == dims.w_m2);
    assign row_last = (eff.row == dims.h_m2);

    always_comb
    begin
        adv = eff;
        unique case (eff.phase) inside
            PH_TOP, PH_BOT:
            begin
                if (eff.slot == 2'd0)
                    adv.slot = 2'd1;
                else
                begin
                    adv.slot = 2'd0;
                    if (col_last)
                    begin
                        adv.col = '0;
                        if (row_last)
                        begin
                            adv.row      = '0;
                            adv.row_base = '0;
                            adv.phase    = (eff.phase == PH_TOP) ? PH_ROW : PH_TOP;
                        end
                        else
                        begin
                            adv.row      = eff.row + 10'd1;
                            adv.row_base = eff.row_base + IDX_W'(dims.w);
                        end
                    end
                    else
                        adv.col = eff.col + 10'd1;
                end
            end
            PH_ROW:
            begin
                if (eff.slot != SLOT_LAST)
                    adv.slot = eff.slot + 2'd1;
                else
                begin
                    adv.slot = 2'd0;
                    if (row_last)
                    begin
                        adv.row      = '0;
                        adv.row_base = '0;
                        adv.phase    = PH_COL;
                    end
                    else
                    begin
                        adv.row      = eff.row + 10'd1;
                        adv.row_base = eff.row_base + IDX_W'(dims.w);
                    end
                end
            end
            PH_COL:
            begin
                if (eff.slot != SLOT_LAST)
                    adv.slot = eff.slot + 2'd1;
                else
                begin
                    adv.slot = 2'd0;
                    if (col_last)
                    begin
                        adv.col   = '0;
                        adv.phase = PH_BOT;
                    end
                    else
                        adv.col = eff.col + 10'd1;
                end
            end
        endcase
    end

    always_comb
    begin
        if (rewind)
            state_next = '0;
        else if (accept)
            state_next = adv;
        else
            state_next = state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/gmsig_tri.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmsig_tri
// triangle corner computation for the current position
// ----------------------------------------------------------------------------
module gmsig_tri (
    input  gmsig_pkg::gen_state_t cur,
    input  gmsig_pkg::dims_t      dims,
    output gmsig_pkg::tri_t       tri_o
);
    import gmsig_pkg::*;

    localparam logic [IDX_W-1:0] ONE = IDX_W'(1);

    logic [IDX_W-1:0] w;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] v_cell;   // row_base + col
    logic [IDX_W-1:0] v_bot;    // cell vertex on the bottom surface
    logic [IDX_W-1:0] v_top;    // selected surface base
    logic [IDX_W-1:0] s_p;      // row skirt, right edge of this row
    logic [IDX_W-1:0] s_q;      // row skirt, right edge of next row
    logic [IDX_W-1:0] c_l;      // column skirt, back edge vertex

    assign w      = IDX_W'(dims.w);
    assign col    = IDX_W'(cur.col);
    assign v_cell = cur.row_base + col;
    assign v_bot  = v_cell + dims.n;
    assign v_top  = (cur.phase == PH_BOT) ? v_bot : v_cell;
    assign s_p    = cur.row_base + w - ONE;
    assign s_q    = s_p + w;
    assign c_l    = col + dims.l;

    always_comb
    begin
        tri_o.a      = '0;
        tri_o.b      = '0;
        tri_o.c      = '0;
        tri_o.region = cur.phase;
        tri_o.last   = (cur.phase == PH_BOT) && (cur.slot == 2'd1)
                       && (cur.col == dims.w_m2) && (cur.row == dims.h_m2);
        case (cur.phase)
            PH_TOP:
            begin
                if (cur.slot == 2'd0)
                begin
                    tri_o.a = v_top;
                    tri_o.b = v_top + w;
                    tri_o.c = v_top + ONE;
                end
                else
                begin
                    tri_o.a = v_top + ONE;
                    tri_o.b = v_top + w;
                    tri_o.c = v_top + w + ONE;
                end
            end
            PH_BOT:
            begin
                if (cur.slot == 2'd0)
                begin
                    tri_o.a = v_top;
                    tri_o.b = v_top + ONE;
                    tri_o.c = v_top + w;
                end
                else
                begin
                    tri_o.a = v_top + w;
                    tri_o.b = v_top + ONE;
                    tri_o.c = v_top + w + ONE;
                end
            end
            PH_ROW:
            begin
                case (cur.slot)
                    2'd0:
                    begin
                        tri_o.a = cur.row_base;
                        tri_o.b = cur.row_base + dims.n;
                        tri_o.c = cur.row_base + w;
                    end
                    2'd1:
                    begin
                        tri_o.a = cur.row_base + w;
                        tri_o.b = cur.row_base + dims.n;
                        tri_o.c = cur.row_base + w + dims.n;
                    end
                    2'd2:
                    begin
                        tri_o.a = s_p;
                        tri_o.b = s_q;
                        tri_o.c = s_p + dims.n;
                    end
                    default:
                    begin
                        tri_o.a = s_p + dims.n;
                        tri_o.b = s_q;
                        tri_o.c = s_q + dims.n;
                    end
                endcase
            end
            default:
            begin
                case (cur.slot)
                    2'd0:
                    begin
                        tri_o.a = col;
                        tri_o.b = col + ONE;
                        tri_o.c = col + dims.n;
                    end
                    2'd1:
                    begin
                        tri_o.a = col + dims.n;
                        tri_o.b = col + ONE;
                        tri_o.c = col + ONE + dims.n;
                    end
                    2'd2:
                    begin
                        tri_o.a = c_l;
                        tri_o.b = c_l + dims.n;
                        tri_o.c = c_l + ONE;
                    end
                    default:
                    begin
                        tri_o.a = c_l + dims.n;
                        tri_o.b = c_l + ONE + dims.n;
                        tri_o.c = c_l + ONE;
                    end
                endcase
            end
        endcase
    end

endmodule
